// ----- rtl/hsv_to_rgb_dimmed_macros.svh -----
// assertion helpers used by hsvd_pipe
// all checks are clocked on i_clk and held off while i_rst_n is low
`ifndef HSV_TO_RGB_DIMMED_MACROS_SVH
`define HSV_TO_RGB_DIMMED_MACROS_SVH

// same-cycle implication
`define HSVD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define HSVD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/hsvd_pkg.sv -----
`timescale 1ns / 1ps
package hsvd_pkg;

    localparam logic OP_CONVERT     = 1'b0;
    localparam logic OP_CURVE_WRITE = 1'b1;

    localparam int CURVE_DEPTH = 256;
    localparam int CURVE_WIDTH = 8;

    localparam logic [8:0] HUE_FULL   = 9'd360;
    localparam logic [8:0] SECTOR_DEG = 9'd60;
    localparam logic [5:0] FRAC_FULL  = 6'd60;

    // floor(p / 60) == (p * RECIP_60) >> RECIP_SHIFT for every p below 2^14
    localparam logic [14:0] RECIP_60    = 15'd17477;
    localparam int          RECIP_SHIFT = 20;

    typedef enum logic [2:0] {
        SEC_R_TO_Y = 3'd0,
        SEC_Y_TO_G = 3'd1,
        SEC_G_TO_C = 3'd2,
        SEC_C_TO_B = 3'd3,
        SEC_B_TO_M = 3'd4,
        SEC_M_TO_R = 3'd5
    } t_sector;

    typedef struct packed {
        logic       opcode;
        logic [8:0] hue;
        logic [7:0] saturation;
        logic [7:0] brightness;
        logic [7:0] curve_index;
        logic [7:0] curve_value;
    } t_in_req;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_out_req;

    // hue position handed from the lookup stage to the math pipeline
    typedef struct packed {
        t_sector    sector;
        logic [5:0] frac;
    } t_hue_pos;

endpackage

// ----- rtl/hsvd_ram.sv -----
`timescale 1ns / 1ps
module hsvd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/hsvd_pipe.sv -----
`timescale 1ns / 1ps
`include "hsv_to_rgb_dimmed_macros.svh"
module hsvd_pipe (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s1_valid,
    input  hsvd_pkg::t_hue_pos i_s1_pos,
    input  logic [7:0]        i_s1_val,
    input  logic [7:0]        i_s1_dsat,
    output logic              o_s1_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output hsvd_pkg::t_out_req o_out_data
);
    import hsvd_pkg::*;

    typedef struct packed {
        t_hue_pos   pos;
        logic [7:0] val;
        logic [7:0] base;
        logic       gray;
    } t_s2;

    typedef struct packed {
        t_sector     sector;
        logic [7:0]  val;
        logic [7:0]  base;
        logic        gray;
        logic [13:0] product;
    } t_s3;

    logic     r_v2, r_v3, r_out_valid;
    t_s2      r_s2, n_s2;
    t_s3      r_s3, n_s3;
    t_out_req r_out, n_out;

    logic        out_free, rdy3, rdy2;
    logic [15:0] base_full;
    logic        up;
    logic [7:0]  diff;
    logic [5:0]  weight;
    logic [28:0] recip_prod;
    logic [7:0]  quot;
    logic [7:0]  blend;

    assign out_free   = !r_out_valid || i_out_ready;
    assign rdy3       = !r_v3 || out_free;
    assign rdy2       = !r_v2 || rdy3;
    assign o_s1_ready = rdy2;

    // stage 2: base = (dsat * val) >> 8, where dsat is the curve entry read at 255 - sat
    always_comb begin
        base_full   = i_s1_dsat * i_s1_val;
        n_s2.pos    = i_s1_pos;
        n_s2.val    = i_s1_val;
        n_s2.base   = base_full[15:8];
        n_s2.gray   = (i_s1_dsat == 8'hFF);
    end

    // stage 3: scaled span between base and val
    always_comb begin
        up = (r_s2.pos.sector == SEC_R_TO_Y) || (r_s2.pos.sector == SEC_G_TO_C)
            || (r_s2.pos.sector == SEC_B_TO_M);
        diff         = r_s2.val - r_s2.base;
        weight       = up ? r_s2.pos.frac : (FRAC_FULL - r_s2.pos.frac);
        n_s3.sector  = r_s2.pos.sector;
        n_s3.val     = r_s2.val;
        n_s3.base    = r_s2.base;
        n_s3.gray    = r_s2.gray;
        n_s3.product = diff * weight;
    end

    // stage 4: divide by 60 through the reciprocal, then place the channels
    always_comb begin
        recip_prod = r_s3.product * RECIP_60;
        quot       = recip_prod[RECIP_SHIFT+7:RECIP_SHIFT];
        blend      = quot + r_s3.base;
        n_out      = '{red: r_s3.val, green: r_s3.val, blue: r_s3.val};
        if (!r_s3.gray) begin
            case (r_s3.sector)
                SEC_R_TO_Y: begin
                    n_out = '{red: r_s3.val, green: blend, blue: r_s3.base};
                end
                SEC_Y_TO_G: begin
                    n_out = '{red: blend, green: r_s3.val, blue: r_s3.base};
                end
                SEC_G_TO_C: begin
                    n_out = '{red: r_s3.base, green: r_s3.val, blue: blend};
                end
                SEC_C_TO_B: begin
                    n_out = '{red: r_s3.base, green: blend, blue: r_s3.val};
                end
                SEC_B_TO_M: begin
                    n_out = '{red: blend, green: r_s3.base, blue: r_s3.val};
                end
                default: begin
                    n_out = '{red: r_s3.val, green: r_s3.base, blue: blend};
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (rdy2) begin
                r_v2 <= i_s1_valid;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
            if (out_free) begin
                r_out_valid <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy2 && i_s1_valid) begin
            r_s2 <= n_s2;
        end
        if (rdy3 && r_v2) begin
            r_s3 <= n_s3;
        end
        if (out_free && r_v3) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `HSVD_ASSERT_NOW(a_base_le_val, r_v2, r_s2.base <= r_s2.val, "base above value")
    `HSVD_ASSERT_NOW(a_frac_range, r_v2, r_s2.pos.frac < FRAC_FULL, "hue fraction out of range")
    `HSVD_ASSERT_NOW(a_quot_le_span, r_v3 && !r_s3.gray, quot <= (r_s3.val - r_s3.base),
        "blend beyond value")
    `HSVD_ASSERT_NEXT(a_stall_holds, r_out_valid && !i_out_ready && r_v3, r_v3,
        "stage 3 lost during output stall")

endmodule

// ----- rtl/hsv_to_rgb_dimmed.sv -----
// HSV to RGB converter with a loadable 256-entry dim curve. A request with opcode 0 converts
// one pixel and yields one RGB result through the curve read, stage 2, stage 3 and the output
// register; a request with opcode 1 writes one curve entry at acceptance and yields nothing,
// and the new entry is seen by any pixel accepted in a later cycle. One request is taken
// every cycle unless a stall fills the pipeline: the curve is held in two identical
// single-port-read memories so both lookups (value and inverted saturation) happen in the
// acceptance cycle, and the math that follows is a three-stage pipeline with its own
// valid/ready chain, the last stage being the registered output, so input ready stays high
// while a result waits as long as a pipeline stage is free. Hue 360 acts as 0 and 361 to
// 511 act as 1 to 151. Pixels must only look up curve entries that were written before.
`timescale 1ns / 1ps
module hsv_to_rgb_dimmed (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  hsvd_pkg::t_in_req i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output hsvd_pkg::t_out_req o_out_data
);
    import hsvd_pkg::*;

    localparam int AW = $clog2(CURVE_DEPTH);

    logic       accept, wr_en, rd_en, s1_ready;
    logic [8:0] hue_wrap;
    t_hue_pos   n_pos, r_pos;
    logic       r_v1;
    logic [7:0] val_raw, dsat_raw;
    logic [AW-1:0] sat_addr;

    assign o_in_ready = !r_v1 || s1_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign wr_en      = accept && (i_in_data.opcode == OP_CURVE_WRITE);
    assign rd_en      = accept && (i_in_data.opcode == OP_CONVERT);
    assign sat_addr   = ~i_in_data.saturation;

    // split hue into 60 degree sector and offset inside it
    always_comb begin
        hue_wrap = (i_in_data.hue >= HUE_FULL) ? (i_in_data.hue - HUE_FULL) : i_in_data.hue;
        if (hue_wrap < SECTOR_DEG) begin
            n_pos.sector = SEC_R_TO_Y;
            n_pos.frac   = hue_wrap[5:0];
        end else if (hue_wrap < 9'(2 * SECTOR_DEG)) begin
            n_pos.sector = SEC_Y_TO_G;
            n_pos.frac   = 6'(hue_wrap - SECTOR_DEG);
        end else if (hue_wrap < 9'(3 * SECTOR_DEG)) begin
            n_pos.sector = SEC_G_TO_C;
            n_pos.frac   = 6'(hue_wrap - 9'(2 * SECTOR_DEG));
        end else if (hue_wrap < 9'(4 * SECTOR_DEG)) begin
            n_pos.sector = SEC_C_TO_B;
            n_pos.frac   = 6'(hue_wrap - 9'(3 * SECTOR_DEG));
        end else if (hue_wrap < 9'(5 * SECTOR_DEG)) begin
            n_pos.sector = SEC_B_TO_M;
            n_pos.frac   = 6'(hue_wrap - 9'(4 * SECTOR_DEG));
        end else begin
            n_pos.sector = SEC_M_TO_R;
            n_pos.frac   = 6'(hue_wrap - 9'(5 * SECTOR_DEG));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (o_in_ready) begin
            r_v1 <= rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_pos <= n_pos;
        end
    end

    // both copies take every curve write
    hsvd_ram #(
        .WIDTH(CURVE_WIDTH),
        .DEPTH(CURVE_DEPTH)
    ) u_curve_val (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (i_in_data.curve_index),
        .i_wr_data (i_in_data.curve_value),
        .i_rd_en   (rd_en),
        .i_rd_addr (i_in_data.brightness),
        .o_rd_data (val_raw)
    );

    hsvd_ram #(
        .WIDTH(CURVE_WIDTH),
        .DEPTH(CURVE_DEPTH)
    ) u_curve_sat (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (i_in_data.curve_index),
        .i_wr_data (i_in_data.curve_value),
        .i_rd_en   (rd_en),
        .i_rd_addr (sat_addr),
        .o_rd_data (dsat_raw)
    );

    hsvd_pipe u_pipe (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s1_valid  (r_v1),
        .i_s1_pos    (r_pos),
        .i_s1_val    (val_raw),
        .i_s1_dsat   (dsat_raw),
        .o_s1_ready  (s1_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
